FILE: rtl/ufsr_pkg.sv
// Shared types and constants for the union-find engine.
// No dependencies; used by ufsr_ctrl, ufsr_dp, union_find_size_rank and the bench.
package ufsr_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int STEP_W     = $clog2(NODE_COUNT + 1);
    localparam int SIZE_W     = 11;
    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = ((CMD_W + 2 * NODE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((NODE_W + SIZE_W + 1 + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(NODE_COUNT);

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init_wr;
        logic walk_adv;
        logic walk_end;
        logic comp_wr;
        logic next_find;
        logic size_rd_ra;
        logic cap_size_a;
        logic res_init;
        logic res_find;
        logic res_merge;
        logic out_load;
    } ufsr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_init;
        logic is_merge;
        logic walk_done;
        logic comp_done;
        logic out_free;
    } ufsr_stat_t;

endpackage

FILE: rtl/ufsr_ctrl.sv
// Sequencer for the union-find engine: init, walk, compression, merge and result hand-off.
// Depends on ufsr_pkg; drives ufsr_dp through ufsr_cmd_t.
module ufsr_ctrl
    import ufsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ufsr_stat_t stat,
    output ufsr_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_WRD   = 4'd2;
    localparam logic [3:0] ST_WCHK  = 4'd3;
    localparam logic [3:0] ST_CRD   = 4'd4;
    localparam logic [3:0] ST_CCHK  = 4'd5;
    localparam logic [3:0] ST_FDONE = 4'd6;
    localparam logic [3:0] ST_MSA   = 4'd7;
    localparam logic [3:0] ST_MSB   = 4'd8;
    localparam logic [3:0] ST_FSZ   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       phase_reg;
    logic       phase_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_WRD;
                end
            end
            ST_INIT:
            begin
                cmd.init_wr  = 1'b1;
                cmd.res_init = 1'b1;
                state_next   = ST_OUT;
            end
            ST_WRD:
            begin
                // parent read of cur is in flight; init skips the walk
                state_next = stat.is_init ? ST_INIT : ST_WCHK;
            end
            ST_WCHK:
            begin
                if (stat.walk_done)
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = ST_CRD;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = ST_WRD;
                end
            end
            ST_CRD:
            begin
                state_next = stat.comp_done ? ST_FDONE : ST_CCHK;
            end
            ST_CCHK:
            begin
                cmd.comp_wr = 1'b1;
                state_next  = ST_CRD;
            end
            ST_FDONE:
            begin
                if (stat.is_merge && !phase_reg)
                begin
                    cmd.next_find = 1'b1;
                    phase_next    = 1'b1;
                    state_next    = ST_WRD;
                end
                else if (stat.is_merge)
                begin
                    cmd.size_rd_ra = 1'b1;
                    state_next     = ST_MSA;
                end
                else
                begin
                    state_next = ST_FSZ;
                end
            end
            ST_MSA:
            begin
                cmd.cap_size_a = 1'b1;
                state_next     = ST_MSB;
            end
            ST_MSB:
            begin
                cmd.res_merge = 1'b1;
                state_next    = ST_OUT;
            end
            ST_FSZ:
            begin
                cmd.res_find = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: rtl/ufsr_dp.sv
// Datapath of the union-find engine: parent and size memories, walk registers, result stage.
// Depends on ufsr_pkg; sequenced by ufsr_ctrl.
module ufsr_dp
    import ufsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] in_data,
    input  ufsr_cmd_t            cmd,
    output ufsr_stat_t           stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [M_TDATA_W-1:0] out_data
);

    logic [NODE_W-1:0] parent_mem [NODE_COUNT];
    logic [SIZE_W-1:0] size_mem   [NODE_COUNT];

    logic [NODE_W-1:0] prdata_reg;
    logic [SIZE_W-1:0] srdata_reg;

    logic [CMD_W-1:0]  op_reg;
    logic [NODE_W-1:0] b_reg;
    logic [NODE_W-1:0] start_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] root_reg;
    logic [NODE_W-1:0] ra_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [SIZE_W-1:0] size_a_reg;
    logic [NODE_W-1:0] res_root_reg;
    logic [SIZE_W-1:0] res_size_reg;
    logic              res_merge_reg;
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [NODE_W-1:0] in_first;
    logic [NODE_W-1:0] in_second;
    logic [CMD_W-1:0]  in_cmd;

    logic              same_root;
    logic              swap;
    logic [NODE_W-1:0] winner;
    logic [NODE_W-1:0] loser;
    logic [SIZE_W:0]   sum_wide;
    logic [SIZE_W-1:0] sum_sat;

    logic              p_we;
    logic [NODE_W-1:0] p_waddr;
    logic [NODE_W-1:0] p_wdata;
    logic              s_we;
    logic [NODE_W-1:0] s_waddr;
    logic [SIZE_W-1:0] s_wdata;
    logic [NODE_W-1:0] s_raddr;

    assign in_cmd    = in_data[CMD_W-1:0];
    assign in_first  = in_data[CMD_W +: NODE_W];
    assign in_second = in_data[CMD_W+NODE_W +: NODE_W];

    // root_reg holds rb during the merge tail
    assign same_root = (ra_reg == root_reg);
    assign swap      = (size_a_reg < srdata_reg);
    assign winner    = swap ? root_reg : ra_reg;
    assign loser     = swap ? ra_reg : root_reg;
    assign sum_wide  = {1'b0, size_a_reg} + {1'b0, srdata_reg};
    assign sum_sat   = sum_wide[SIZE_W] ? SIZE_MAX : sum_wide[SIZE_W-1:0];

    assign stat.is_init   = (op_reg == CMD_INIT);
    assign stat.is_merge  = (op_reg == CMD_MERGE);
    assign stat.walk_done = (prdata_reg == cur_reg) || (steps_reg == STEP_LIMIT);
    assign stat.comp_done = (cur_reg == root_reg) || (steps_reg == STEP_LIMIT);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        p_we    = 1'b0;
        p_waddr = cur_reg;
        p_wdata = root_reg;
        s_we    = 1'b0;
        s_waddr = winner;
        s_wdata = sum_sat;
        if (cmd.init_wr)
        begin
            p_we    = 1'b1;
            p_waddr = start_reg;
            p_wdata = start_reg;
            s_we    = 1'b1;
            s_waddr = start_reg;
            s_wdata = SIZE_W'(1);
        end
        else if (cmd.comp_wr)
        begin
            p_we = 1'b1;
        end
        else if (cmd.res_merge && !same_root)
        begin
            p_we    = 1'b1;
            p_waddr = loser;
            p_wdata = winner;
            s_we    = 1'b1;
        end
    end

    assign s_raddr = cmd.size_rd_ra ? ra_reg : root_reg;

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        prdata_reg <= parent_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            size_mem[s_waddr] <= s_wdata;
        end
        srdata_reg <= size_mem[s_raddr];
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_cmd;
            b_reg     <= in_second;
            start_reg <= in_first;
            cur_reg   <= in_first;
            steps_reg <= '0;
        end
        if (cmd.walk_adv)
        begin
            cur_reg   <= prdata_reg;
            steps_reg <= steps_reg + STEP_W'(1);
        end
        if (cmd.walk_end)
        begin
            root_reg  <= cur_reg;
            cur_reg   <= start_reg;
            steps_reg <= '0;
        end
        if (cmd.comp_wr)
        begin
            cur_reg   <= prdata_reg;
            steps_reg <= steps_reg + STEP_W'(1);
        end
        if (cmd.next_find)
        begin
            ra_reg    <= root_reg;
            start_reg <= b_reg;
            cur_reg   <= b_reg;
            steps_reg <= '0;
        end
        if (cmd.cap_size_a)
        begin
            size_a_reg <= srdata_reg;
        end
        if (cmd.res_init)
        begin
            res_root_reg  <= start_reg;
            res_size_reg  <= SIZE_W'(1);
            res_merge_reg <= 1'b0;
        end
        if (cmd.res_find)
        begin
            res_root_reg  <= root_reg;
            res_size_reg  <= srdata_reg;
            res_merge_reg <= 1'b0;
        end
        if (cmd.res_merge)
        begin
            res_root_reg  <= same_root ? ra_reg : winner;
            res_size_reg  <= same_root ? size_a_reg : sum_sat;
            res_merge_reg <= !same_root;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= M_TDATA_W'({res_merge_reg, res_size_reg, res_root_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/union_find_size_rank.sv
// Union-find engine (union by size, path compression): top level.
// Block usage:
//   Input stream s_axis_*: one beat per operation (init, find, merge).
//   Output stream m_axis_*: exactly one beat per operation, in order.
//   One operation is worked at a time. An init writes the node as its own
//   root. A find walks to the root, each link taking a read state and a
//   check state, then compresses the path, each link taking a read state
//   and a write state; both passes are bounded by the single read port of
//   the parent memory. A merge does both finds, then the size reads and
//   the link. m_axis_tvalid rises in the same cycle as s_axis_tready.
//   s_axis_tready is high only while no operation is in flight; a finished
//   result sits in the output register, so the next beat can be taken while
//   it waits for m_axis_tready. A stalled receiver holds m_axis_tdata steady
//   and stops the engine only once a second result is ready.
//   Reset clears control state only; the parent and size memories hold
//   nothing valid, so every node must be initialised before it is used.
// Depends on ufsr_pkg, ufsr_ctrl and ufsr_dp.
module union_find_size_rank
    import ufsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // cmd, first_node, second_node, zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // root_node, set_size, did_merge, zero pad
);

    ufsr_cmd_t  cmd;
    ufsr_stat_t stat;

    ufsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ufsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // one operation at a time: an accepted beat closes the input
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an operation is in flight");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");

    // at most one writer of the parent memory per cycle
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.init_wr, cmd.comp_wr, cmd.res_merge}))
        else $error("conflicting memory writes");
`endif

endmodule

FILE: bench/dsu_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the union-find engine: a predictor of the parent and size tables
// and a queue of expected result beats. Depends on ufsr_pkg.
package dsu_check_pkg;
    import ufsr_pkg::*;

    typedef struct packed {
        logic              did_merge;
        logic [SIZE_W-1:0] set_size;
        logic [NODE_W-1:0] root_node;
    } dsu_result_t;

    class dsu_scoreboard;
        logic [NODE_W-1:0] parent_mem [NODE_COUNT];
        logic [SIZE_W-1:0] size_mem [NODE_COUNT];
        dsu_result_t       expected_q [$];
        int                errors;

        function new();
            foreach (parent_mem[i])
            begin
                parent_mem[i] = '0;
                size_mem[i]   = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // walk up to the root, then point every node on the path straight at it
        function logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] node);
            logic [NODE_W-1:0] root;
            logic [NODE_W-1:0] cur;
            logic [NODE_W-1:0] nxt;
            int                steps;
            root  = node;
            steps = 0;
            while (steps < NODE_COUNT && parent_mem[root] != root)
            begin
                root = parent_mem[root];
                steps++;
            end
            cur   = node;
            steps = 0;
            while (cur != root && steps < NODE_COUNT)
            begin
                nxt             = parent_mem[cur];
                parent_mem[cur] = root;
                cur             = nxt;
                steps++;
            end
            return root;
        endfunction

        // accepted input beat: cmd, first_node, second_node from bit 0 up
        function void note_op(logic [S_TDATA_W-1:0] beat);
            logic [CMD_W-1:0]  cmd;
            logic [NODE_W-1:0] node_a;
            logic [NODE_W-1:0] node_b;
            logic [NODE_W-1:0] root_a;
            logic [NODE_W-1:0] root_b;
            logic [NODE_W-1:0] swap;
            logic [SIZE_W:0]   sum;
            dsu_result_t       res;
            cmd    = beat[CMD_W-1:0];
            node_a = beat[CMD_W +: NODE_W];
            node_b = beat[CMD_W + NODE_W +: NODE_W];
            res    = '0;
            if (cmd == CMD_INIT)
            begin
                parent_mem[node_a] = node_a;
                size_mem[node_a]   = SIZE_W'(1);
                root_a             = node_a;
            end
            else if (cmd == CMD_MERGE)
            begin
                root_a = find_root(node_a);
                root_b = find_root(node_b);
                if (root_a != root_b)
                begin
                    // smaller set goes under the larger; a tie keeps the first root
                    if (size_mem[root_a] < size_mem[root_b])
                    begin
                        swap   = root_a;
                        root_a = root_b;
                        root_b = swap;
                    end
                    parent_mem[root_b] = root_a;
                    sum = {1'b0, size_mem[root_a]} + {1'b0, size_mem[root_b]};
                    size_mem[root_a] = (sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : sum[SIZE_W-1:0];
                    res.did_merge = 1'b1;
                end
            end
            else
                root_a = find_root(node_a);
            res.root_node = root_a;
            res.set_size  = size_mem[root_a];
            expected_q    = {expected_q, res};
        endfunction

        // accepted output beat: root_node, set_size, did_merge from bit 0 up
        function void check_beat(logic [M_TDATA_W-1:0] beat);
            dsu_result_t got;
            dsu_result_t exp_res;
            got.root_node = beat[NODE_W-1:0];
            got.set_size  = beat[NODE_W +: SIZE_W];
            got.did_merge = beat[NODE_W + SIZE_W];
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result beat root %0d size %0d merge %0d",
                         $time, got.root_node, got.set_size, got.did_merge);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.root_node != exp_res.root_node)
            begin
                $display("%0t: root_node expected %0d actual %0d",
                         $time, exp_res.root_node, got.root_node);
                errors++;
            end
            if (got.set_size != exp_res.set_size)
            begin
                $display("%0t: set_size expected %0d actual %0d",
                         $time, exp_res.set_size, got.set_size);
                errors++;
            end
            if (got.did_merge != exp_res.did_merge)
            begin
                $display("%0t: did_merge expected %0d actual %0d",
                         $time, exp_res.did_merge, got.did_merge);
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top-level bench for union_find_size_rank: directed, random and hub-growth
// streams with random stalls on both sides. Depends on ufsr_pkg and dsu_check_pkg.
module testbench;
    import ufsr_pkg::*;
    import dsu_check_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_OPS   = 500;
    localparam int HUB_PAIRS    = 40;
    localparam int DRAIN_CYCLES = 40;

    // the fourth command code, which the block treats as a find
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // cmd, first_node, second_node, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // root_node, set_size, did_merge, zero pad

    dsu_scoreboard     dsu_sb;
    bit                live_node [NODE_COUNT];
    logic [NODE_W-1:0] live_list [$];
    bit                calm;
    int                op_count;
    int                idle_cycles;
    int                ready_left;

    union_find_size_rank dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver: runs of ready and stalls, mostly short; none while calm
    always @(posedge clk)
    begin
        int pick;
        if (calm)
            m_axis_tready <= 1'b1;
        else if (ready_left > 0)
            ready_left--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                m_axis_tready <= 1'b1;
                ready_left = $urandom_range(0, 20);
            end
            else if (pick < 95)
            begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_left = $urandom_range(15, 60);
            end
        end
    end

    // beat monitors and watchdog
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            dsu_sb.note_op(s_axis_tdata);
            moved = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            dsu_sb.check_beat(m_axis_tdata);
            moved = 1'b1;
        end
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [NODE_W-1:0] rand_node();
        return NODE_W'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    function automatic logic [NODE_W-1:0] pick_live();
        return live_list[$urandom_range(0, live_list.size() - 1)];
    endfunction

    task automatic pause_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (calm || pick < 70)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node_a,
                           input logic [NODE_W-1:0] node_b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({node_b, node_a, cmd});
        if (cmd == CMD_INIT && !live_node[node_a])
        begin
            live_node[node_a] = 1'b1;
            live_list         = {live_list, node_a};
        end
        do @(posedge clk); while (!s_axis_tready);
        op_count++;
        if (op_count % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
        pause_gap();
    endtask

    // hold the sender until every expected result beat has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (dsu_sb.pending() != 0);
    endtask

    initial
    begin
        int                pick;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] hub;
        logic [CMD_W-1:0]  cmd;
        dsu_sb      = new();
        calm        = 1'b0;
        op_count    = 0;
        idle_cycles = 0;
        ready_left  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, ties, self merge, stale sizes
        send_op(CMD_INIT, 10'd0, rand_node());
        send_op(CMD_INIT, 10'd1023, rand_node());
        send_op(CMD_FIND, 10'd0, rand_node());
        send_op(CMD_MERGE, 10'd0, 10'd1023);        // equal sizes keep the first root
        send_op(CMD_FIND, 10'd1023, rand_node());
        send_op(CMD_SPARE, 10'd1023, rand_node());
        send_op(CMD_MERGE, 10'd1023, 10'd0);        // already one set
        send_op(CMD_INIT, 10'd512, rand_node());
        send_op(CMD_MERGE, 10'd512, 10'd0);         // smaller first set is swapped under
        send_op(CMD_INIT, 10'd341, 10'd682);
        send_op(CMD_INIT, 10'd682, 10'd341);
        send_op(CMD_MERGE, 10'd341, 10'd682);
        send_op(CMD_MERGE, 10'd341, 10'd0);
        send_op(CMD_FIND, 10'd682, rand_node());    // two-link path, compressed
        send_op(CMD_SPARE, 10'd682, rand_node());
        send_op(CMD_INIT, 10'd0, rand_node());      // re-init of a root with children
        send_op(CMD_FIND, 10'd682, rand_node());
        send_op(CMD_INIT, 10'd1023, rand_node());   // re-init of a non-root
        send_op(CMD_MERGE, 10'd1023, 10'd682);
        send_op(CMD_MERGE, 10'd512, 10'd341);
        send_op(CMD_FIND, 10'd341, rand_node());
        drain();

        // random: mostly finds and merges over nodes already initialised
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 200 == 150)
                drain();
            pick = $urandom_range(0, 99);
            if (live_list.size() < 2 || pick < 25)
            begin
                if (live_list.size() > 0 && $urandom_range(0, 9) == 0)
                    node_a = pick_live();
                else
                    node_a = rand_node();
                send_op(CMD_INIT, node_a, rand_node());
            end
            else if (pick < 55)
            begin
                cmd = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_FIND;
                send_op(cmd, pick_live(), rand_node());
            end
            else
            begin
                node_a = pick_live();
                node_b = ($urandom_range(0, 19) == 0) ? node_a : pick_live();
                send_op(CMD_MERGE, node_a, node_b);
            end
        end
        drain();

        // hub growth: a fresh hub absorbs re-initialised leaves, stale sizes pile up
        calm = 1'b1;
        hub  = rand_node();
        send_op(CMD_INIT, hub, rand_node());
        for (int j = 0; j < HUB_PAIRS; j++)
        begin
            node_b = hub + NODE_W'($urandom_range(1, 4));
            send_op(CMD_INIT, node_b, rand_node());
            if (j > 0 && j[0])
                send_op(CMD_MERGE, node_b, hub);
            else
                send_op(CMD_MERGE, hub, node_b);
        end
        calm = 1'b0;
        send_op(CMD_FIND, node_b, rand_node());

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dsu_sb.errors == 0 && dsu_sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ufsr_pkg.sv
rtl/ufsr_ctrl.sv
rtl/ufsr_dp.sv
rtl/union_find_size_rank.sv
bench/dsu_check_pkg.sv
bench/testbench.sv
